[design/seccal_pkg.sv]
// Shared widths, constants and reciprocal tables for the seconds-to-calendar converter.
package seccal_pkg;

    localparam int SECS_W  = 32;
    localparam int SEC_W   = 6;
    localparam int MIN_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int DOM_W   = 5;
    localparam int MON_W   = 4;
    localparam int YEAR_W  = 8;
    localparam int WDAY_W  = 3;

    // day split: secs >> 7, then divide by 675 (86400 = 128 * 675)
    localparam int DAY_SHIFT   = 7;
    localparam int DAY_IN_W    = SECS_W - DAY_SHIFT;
    localparam int DAY_K       = 35;
    localparam int RECIP_DAY_W = 26;
    localparam logic [RECIP_DAY_W-1:0] RECIP_DAY =
        RECIP_DAY_W'(((64'd1 << DAY_K) + 64'd674) / 64'd675);
    localparam int DAYS_W = 16;
    localparam int TOD_W  = 17;
    localparam logic [SECS_W-1:0] SECS_PER_DAY = 32'd86400;

    // Julian day number
    localparam int JDN_W = 22;
    localparam logic [JDN_W-1:0] EPOCH_JDN = 22'd2451545;

    // hour of day
    localparam int HOUR_K       = 29;
    localparam int RECIP_HOUR_W = 18;
    localparam logic [RECIP_HOUR_W-1:0] RECIP_HOUR =
        RECIP_HOUR_W'(((64'd1 << HOUR_K) + 64'd3599) / 64'd3600);
    localparam logic [TOD_W-1:0] SECS_PER_HOUR = 17'd3600;

    // minute of hour
    localparam int MSEC_W      = 12;
    localparam int MIN_K       = 18;
    localparam int RECIP_MIN_W = 13;
    localparam logic [RECIP_MIN_W-1:0] RECIP_MIN =
        RECIP_MIN_W'(((64'd1 << MIN_K) + 64'd59) / 64'd60);
    localparam logic [MSEC_W-1:0] SECS_PER_MIN = 12'd60;

    // weekday
    localparam int WEEK_K       = 25;
    localparam int RECIP_WEEK_W = 23;
    localparam logic [RECIP_WEEK_W-1:0] RECIP_WEEK =
        RECIP_WEEK_W'(((64'd1 << WEEK_K) + 64'd6) / 64'd7);
    localparam int WKQ_W = 19;
    localparam logic [JDN_W-1:0] DAYS_PER_WEEK = 22'd7;
    localparam logic [WDAY_W-1:0] WDAY_SUNDAY  = 3'd7;

    // Gregorian correction; the input range keeps alpha within 15..17
    localparam int ALPHA_W = 5;
    localparam int JDN4_W  = JDN_W + 2;
    localparam logic [ALPHA_W-1:0] ALPHA_MIN = 5'd15;
    localparam logic [JDN4_W-1:0] ALPHA_T16 = 24'(7468865 + 16 * 146097);
    localparam logic [JDN4_W-1:0] ALPHA_T17 = 24'(7468865 + 17 * 146097);
    localparam logic [JDN_W-1:0]  B_OFFSET  = 22'd1525;

    // c = (20 b - 2442) / 7305
    localparam int NUMC_W    = 26;
    localparam int C_K       = 39;
    localparam int RECIP_C_W = 27;
    localparam logic [RECIP_C_W-1:0] RECIP_C =
        RECIP_C_W'(((64'd1 << C_K) + 64'd7304) / 64'd7305);
    localparam logic [NUMC_W-1:0] C_SCALE = 26'd20;
    localparam logic [NUMC_W-1:0] C_BIAS  = 26'd2442;
    localparam int C_W = 13;

    // d = c * 1461 / 4
    localparam int D_PROD_W = C_W + 11;
    localparam logic [D_PROD_W-1:0] DAYS_PER_4Y = 24'd1461;
    localparam int BD_W = 9;

    // e = (bd * 10000) / 306001, both constants folded into one reciprocal
    localparam int E_K       = 42;
    localparam int RECIP_E_W = 38;
    localparam logic [RECIP_E_W-1:0] RECIP_E =
        RECIP_E_W'(64'd10000 * (((64'd1 << E_K) + 64'd306000) / 64'd306001));
    localparam int E_W = 4;
    localparam logic [E_W-1:0] MONTH_WRAP = 4'd14;
    localparam logic [E_W-1:0] MONTH_OFS_LO = 4'd1;
    localparam logic [E_W-1:0] MONTH_OFS_HI = 4'd13;
    localparam logic [MON_W-1:0] MONTH_MARCH = 4'd3;

    // floor(306001 * e / 10000)
    localparam logic [BD_W-1:0] DAY_OFFSET [1 << E_W] = '{
        9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
        9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
    };

    // c - 4715 - 2000 before March, c - 4716 - 2000 from March on
    localparam logic [C_W-1:0] YEAR_BIAS_EARLY = 13'd6715;
    localparam logic [C_W-1:0] YEAR_BIAS_LATE  = 13'd6716;

    localparam int NUM_STAGES = 8;

endpackage

[design/seconds_since_2000_to_calendar.sv]
// Top level: pipelined seconds-since-2000 to calendar date and time converter.
//
// Input channel s_*: one word is a 32-bit unsigned count of seconds since
// 2000-01-01 00:00:00 UTC. Result channel m_*: second, minute, hour, day of
// month, month, year since 2000 and weekday (1 Monday .. 7 Sunday).
// Both channels are valid/ready; a word moves when valid and ready are high.
//
// Each accepted word passes through the stage registers in order before m_valid rises.
// Throughput: one word per cycle while the receiver is ready, set by the eight
// register stages; each stage's longest path holds at most one constant multiply,
// and every divide is done by reciprocal multiplication.
//
// Reset (aresetn low, synchronous) clears all stage valid bits; the pipe
// is empty and s_ready is high afterwards.
// Receiver stall: the output stage holds its word; upstream stages keep
// advancing into empty slots, so up to 8 words are taken before s_ready
// drops. Nothing is lost or repeated.
module seconds_since_2000_to_calendar
    import seccal_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [SECS_W-1:0] s_seconds_since_epoch,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [SEC_W-1:0]  m_second_of_minute,
    output logic [MIN_W-1:0]  m_minute_of_hour,
    output logic [HOUR_W-1:0] m_hour_of_day,
    output logic [DOM_W-1:0]  m_day_of_month,
    output logic [MON_W-1:0]  m_month_of_year,
    output logic [YEAR_W-1:0] m_year_since_2000,
    output logic [WDAY_W-1:0] m_weekday
);

    localparam int LAST = NUM_STAGES - 1;

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] stage_en;

    // ---------------- pipeline control ----------------
    always_comb begin
        stage_en[LAST] = !vld_reg[LAST] || m_ready;
        for (int i = LAST - 1; i >= 0; i--) begin
            stage_en[i] = !vld_reg[i] || stage_en[i+1];
        end
    end

    assign vld_next = {vld_reg[NUM_STAGES-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < NUM_STAGES; i++) begin
                if (stage_en[i]) begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    assign s_ready = stage_en[0];
    assign m_valid = vld_reg[LAST];

    // ---------------- stage 1: days estimate ----------------
    logic [DAY_IN_W+RECIP_DAY_W-1:0] day_prod;
    logic [DAYS_W-1:0]               st1_days_reg;
    logic [SECS_W-1:0]               st1_secs_reg;

    assign day_prod = (DAY_IN_W + RECIP_DAY_W)'(s_seconds_since_epoch[SECS_W-1:DAY_SHIFT])
                    * (DAY_IN_W + RECIP_DAY_W)'(RECIP_DAY);

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            st1_days_reg <= day_prod[DAY_K +: DAYS_W];
            st1_secs_reg <= s_seconds_since_epoch;
        end
    end

    // ---------------- stage 2: time of day, Julian day ----------------
    logic [SECS_W-1:0] day_secs;
    logic [SECS_W-1:0] tod_full;
    logic [TOD_W-1:0]  st2_tod_reg;
    logic [JDN_W-1:0]  st2_jdn_reg;

    assign day_secs = SECS_W'(st1_days_reg) * SECS_PER_DAY;
    assign tod_full = st1_secs_reg - day_secs;

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            st2_tod_reg <= tod_full[TOD_W-1:0];
            st2_jdn_reg <= JDN_W'(st1_days_reg) + EPOCH_JDN;
        end
    end

    // ---------------- stage 3: hour, b, weekday quotient ----------------
    logic [TOD_W+RECIP_HOUR_W-1:0]  hour_prod;
    logic [JDN4_W-1:0]              jdn4;
    logic [ALPHA_W-1:0]             alpha;
    logic [JDN_W-1:0]               jdn1;
    logic [JDN_W+RECIP_WEEK_W-1:0]  wk_prod;
    logic [TOD_W-1:0]               st3_tod_reg;
    logic [HOUR_W-1:0]              st3_hour_reg;
    logic [JDN_W-1:0]               st3_b_reg;
    logic [JDN_W-1:0]               st3_jdn1_reg;
    logic [WKQ_W-1:0]               st3_wkq_reg;

    assign hour_prod = (TOD_W + RECIP_HOUR_W)'(st2_tod_reg)
                     * (TOD_W + RECIP_HOUR_W)'(RECIP_HOUR);
    assign jdn4      = {st2_jdn_reg, 2'b00};
    assign alpha     = ALPHA_MIN + ALPHA_W'(jdn4 >= ALPHA_T16) + ALPHA_W'(jdn4 >= ALPHA_T17);
    assign jdn1      = st2_jdn_reg + JDN_W'(1);
    assign wk_prod   = (JDN_W + RECIP_WEEK_W)'(jdn1) * (JDN_W + RECIP_WEEK_W)'(RECIP_WEEK);

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            st3_tod_reg  <= st2_tod_reg;
            st3_hour_reg <= hour_prod[HOUR_K +: HOUR_W];
            st3_b_reg    <= st2_jdn_reg + JDN_W'(alpha) - JDN_W'(alpha >> 2) + B_OFFSET;
            st3_jdn1_reg <= jdn1;
            st3_wkq_reg  <= wk_prod[WEEK_K +: WKQ_W];
        end
    end

    // ---------------- stage 4: seconds of hour, c numerator, weekday ----------------
    logic [TOD_W-1:0]  hour_secs;
    logic [TOD_W-1:0]  rs_full;
    logic [JDN_W-1:0]  wk_mul;
    logic [JDN_W-1:0]  wr_full;
    logic [WDAY_W-1:0] wr;
    logic [MSEC_W-1:0] st4_rs_reg;
    logic [HOUR_W-1:0] st4_hour_reg;
    logic [NUMC_W-1:0] st4_numc_reg;
    logic [JDN_W-1:0]  st4_b_reg;
    logic [WDAY_W-1:0] st4_wd_reg;

    assign hour_secs = TOD_W'(st3_hour_reg) * SECS_PER_HOUR;
    assign rs_full   = st3_tod_reg - hour_secs;
    assign wk_mul    = JDN_W'(st3_wkq_reg) * DAYS_PER_WEEK;
    assign wr_full   = st3_jdn1_reg - wk_mul;
    assign wr        = wr_full[WDAY_W-1:0];

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            st4_rs_reg   <= rs_full[MSEC_W-1:0];
            st4_hour_reg <= st3_hour_reg;
            st4_numc_reg <= NUMC_W'(st3_b_reg) * C_SCALE - C_BIAS;
            st4_b_reg    <= st3_b_reg;
            st4_wd_reg   <= (wr == '0) ? WDAY_SUNDAY : wr;
        end
    end

    // ---------------- stage 5: minute, c ----------------
    logic [MSEC_W+RECIP_MIN_W-1:0] min_prod;
    logic [NUMC_W+RECIP_C_W-1:0]   c_prod;
    logic [MSEC_W-1:0]             st5_rs_reg;
    logic [MIN_W-1:0]              st5_min_reg;
    logic [HOUR_W-1:0]             st5_hour_reg;
    logic [C_W-1:0]                st5_c_reg;
    logic [JDN_W-1:0]              st5_b_reg;
    logic [WDAY_W-1:0]             st5_wd_reg;

    assign min_prod = (MSEC_W + RECIP_MIN_W)'(st4_rs_reg) * (MSEC_W + RECIP_MIN_W)'(RECIP_MIN);
    assign c_prod   = (NUMC_W + RECIP_C_W)'(st4_numc_reg) * (NUMC_W + RECIP_C_W)'(RECIP_C);

    always_ff @(posedge aclk) begin
        if (stage_en[4]) begin
            st5_rs_reg   <= st4_rs_reg;
            st5_min_reg  <= min_prod[MIN_K +: MIN_W];
            st5_hour_reg <= st4_hour_reg;
            st5_c_reg    <= c_prod[C_K +: C_W];
            st5_b_reg    <= st4_b_reg;
            st5_wd_reg   <= st4_wd_reg;
        end
    end

    // ---------------- stage 6: second, b - d ----------------
    logic [MSEC_W-1:0]   min_secs;
    logic [MSEC_W-1:0]   sec_full;
    logic [D_PROD_W-1:0] d_prod;
    logic [JDN_W-1:0]    bd_full;
    logic [SEC_W-1:0]    st6_sec_reg;
    logic [MIN_W-1:0]    st6_min_reg;
    logic [HOUR_W-1:0]   st6_hour_reg;
    logic [WDAY_W-1:0]   st6_wd_reg;
    logic [C_W-1:0]      st6_c_reg;
    logic [BD_W-1:0]     st6_bd_reg;

    assign min_secs = MSEC_W'(st5_min_reg) * SECS_PER_MIN;
    assign sec_full = st5_rs_reg - min_secs;
    assign d_prod   = D_PROD_W'(st5_c_reg) * DAYS_PER_4Y;
    assign bd_full  = st5_b_reg - d_prod[D_PROD_W-1:2];

    always_ff @(posedge aclk) begin
        if (stage_en[5]) begin
            st6_sec_reg  <= sec_full[SEC_W-1:0];
            st6_min_reg  <= st5_min_reg;
            st6_hour_reg <= st5_hour_reg;
            st6_wd_reg   <= st5_wd_reg;
            st6_c_reg    <= st5_c_reg;
            st6_bd_reg   <= bd_full[BD_W-1:0];
        end
    end

    // ---------------- stage 7: e ----------------
    logic [BD_W+RECIP_E_W-1:0] e_prod;
    logic [SEC_W-1:0]          st7_sec_reg;
    logic [MIN_W-1:0]          st7_min_reg;
    logic [HOUR_W-1:0]         st7_hour_reg;
    logic [WDAY_W-1:0]         st7_wd_reg;
    logic [C_W-1:0]            st7_c_reg;
    logic [BD_W-1:0]           st7_bd_reg;
    logic [E_W-1:0]            st7_e_reg;

    assign e_prod = (BD_W + RECIP_E_W)'(st6_bd_reg) * (BD_W + RECIP_E_W)'(RECIP_E);

    always_ff @(posedge aclk) begin
        if (stage_en[6]) begin
            st7_sec_reg  <= st6_sec_reg;
            st7_min_reg  <= st6_min_reg;
            st7_hour_reg <= st6_hour_reg;
            st7_wd_reg   <= st6_wd_reg;
            st7_c_reg    <= st6_c_reg;
            st7_bd_reg   <= st6_bd_reg;
            st7_e_reg    <= e_prod[E_K +: E_W];
        end
    end

    // ---------------- stage 8: output word ----------------
    logic [BD_W-1:0]   dom_full;
    logic [E_W-1:0]    mon_e;
    logic [MON_W-1:0]  mon;
    logic [C_W-1:0]    yr_full;
    logic [SEC_W-1:0]  st8_sec_reg;
    logic [MIN_W-1:0]  st8_min_reg;
    logic [HOUR_W-1:0] st8_hour_reg;
    logic [DOM_W-1:0]  st8_dom_reg;
    logic [MON_W-1:0]  st8_mon_reg;
    logic [YEAR_W-1:0] st8_year_reg;
    logic [WDAY_W-1:0] st8_wd_reg;

    assign dom_full = st7_bd_reg - DAY_OFFSET[st7_e_reg];
    assign mon_e    = (st7_e_reg < MONTH_WRAP) ? (st7_e_reg - MONTH_OFS_LO)
                                               : (st7_e_reg - MONTH_OFS_HI);
    assign mon      = MON_W'(mon_e);
    assign yr_full  = (mon < MONTH_MARCH) ? (st7_c_reg - YEAR_BIAS_EARLY)
                                          : (st7_c_reg - YEAR_BIAS_LATE);

    always_ff @(posedge aclk) begin
        if (stage_en[7]) begin
            st8_sec_reg  <= st7_sec_reg;
            st8_min_reg  <= st7_min_reg;
            st8_hour_reg <= st7_hour_reg;
            st8_dom_reg  <= dom_full[DOM_W-1:0];
            st8_mon_reg  <= mon;
            st8_year_reg <= yr_full[YEAR_W-1:0];
            st8_wd_reg   <= st7_wd_reg;
        end
    end

    assign m_second_of_minute = st8_sec_reg;
    assign m_minute_of_hour   = st8_min_reg;
    assign m_hour_of_day      = st8_hour_reg;
    assign m_day_of_month     = st8_dom_reg;
    assign m_month_of_year    = st8_mon_reg;
    assign m_year_since_2000  = st8_year_reg;
    assign m_weekday          = st8_wd_reg;

endmodule

[design/seccal_chk.sv]
// Port-level checker for the seconds-to-calendar converter, bound to the top level.
module seccal_chk
    import seccal_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic [SECS_W-1:0] s_seconds_since_epoch,
    input logic              m_valid,
    input logic              m_ready,
    input logic [SEC_W-1:0]  m_second_of_minute,
    input logic [MIN_W-1:0]  m_minute_of_hour,
    input logic [HOUR_W-1:0] m_hour_of_day,
    input logic [DOM_W-1:0]  m_day_of_month,
    input logic [MON_W-1:0]  m_month_of_year,
    input logic [YEAR_W-1:0] m_year_since_2000,
    input logic [WDAY_W-1:0] m_weekday
);

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // a free receiver never backs up the input
    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("s_ready low while m_ready high");

    // stalled word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_day_of_month)
            && $stable(m_month_of_year) && $stable(m_year_since_2000)
            && $stable(m_weekday) && $stable(m_second_of_minute))
        else $error("stalled output word changed");

    // calendar fields stay legal
    a_fields_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_month_of_year != '0 && m_month_of_year <= 4'd12
            && m_day_of_month != '0 && m_weekday != '0
            && m_hour_of_day <= 5'd23 && m_minute_of_hour <= 6'd59
            && m_second_of_minute <= 6'd59)
        else $error("output field out of range");

endmodule

bind seconds_since_2000_to_calendar seccal_chk u_seccal_chk (.*);

[test/tb.sv]
// Testbench for the seconds-since-2000 to calendar converter: directed and random timestamps.
module tb
    import seccal_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 3 * NUM_STAGES + 8;
    localparam logic [SECS_W-1:0] LAST_DAY = 32'd49710;

    typedef struct packed {
        logic [SEC_W-1:0]  sec;
        logic [MIN_W-1:0]  min;
        logic [HOUR_W-1:0] hour;
        logic [DOM_W-1:0]  dom;
        logic [MON_W-1:0]  mon;
        logic [YEAR_W-1:0] year;
        logic [WDAY_W-1:0] wday;
    } cal_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [SECS_W-1:0] s_seconds_since_epoch = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [SEC_W-1:0]  m_second_of_minute;
    logic [MIN_W-1:0]  m_minute_of_hour;
    logic [HOUR_W-1:0] m_hour_of_day;
    logic [DOM_W-1:0]  m_day_of_month;
    logic [MON_W-1:0]  m_month_of_year;
    logic [YEAR_W-1:0] m_year_since_2000;
    logic [WDAY_W-1:0] m_weekday;

    cal_t cal_expected[$];
    int   fail_count = 0;
    int   idle_cycles = 0;
    int   sink_hold = 0;
    bit   src_idle_en = 1'b1;
    bit   sink_idle_en = 1'b1;

    seconds_since_2000_to_calendar u_top (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_seconds_since_epoch (s_seconds_since_epoch),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_second_of_minute    (m_second_of_minute),
        .m_minute_of_hour      (m_minute_of_hour),
        .m_hour_of_day         (m_hour_of_day),
        .m_day_of_month        (m_day_of_month),
        .m_month_of_year       (m_month_of_year),
        .m_year_since_2000     (m_year_since_2000),
        .m_weekday             (m_weekday)
    );

    always #2 aclk = ~aclk;

    function automatic cal_t calendar_of(logic [SECS_W-1:0] secs);
        logic [63:0] s, jdn, alpha, a, b, c, d, e, bd, mon, yr, wd;
        cal_t r;
        s = 64'(secs);
        r.sec  = SEC_W'(s % 64'd60);
        r.min  = MIN_W'((s / 64'd60) % 64'd60);
        r.hour = HOUR_W'((s / 64'd3600) % 64'd24);
        jdn = s / 64'd86400 + 64'd2451545;
        wd = (jdn + 64'd1) % 64'd7;
        if (wd == 64'd0) begin
            wd = 64'd7;
        end
        alpha = (64'd4 * jdn - 64'd7468865) / 64'd146097;
        a = jdn + 64'd1 + alpha - alpha / 64'd4;
        b = a + 64'd1524;
        c = (64'd20 * b - 64'd2442) / 64'd7305;
        d = (c * 64'd1461) / 64'd4;
        bd = b - d;
        e = (bd * 64'd10000) / 64'd306001;
        mon = (e < 64'd14) ? (e - 64'd1) : (e - 64'd13);
        yr = ((mon < 64'd3) ? (c - 64'd4715) : (c - 64'd4716)) - 64'd2000;
        r.dom  = DOM_W'(bd - (64'd306001 * e) / 64'd10000);
        r.mon  = MON_W'(mon);
        r.year = YEAR_W'(yr);
        r.wday = WDAY_W'(wd);
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_stamp(input logic [SECS_W-1:0] secs);
        int gap;
        s_valid <= 1'b1;
        s_seconds_since_epoch <= secs;
        do @(posedge aclk); while (!s_ready);
        gap = src_idle_en ? idle_len() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // prediction at acceptance of each timestamp
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            cal_expected.push_back(calendar_of(s_seconds_since_epoch));
        end
    end

    always @(posedge aclk) begin
        cal_t want;
        if (aresetn && m_valid && m_ready) begin
            if (cal_expected.size() == 0) begin
                $error("result word with no timestamp outstanding");
                fail_count++;
            end else begin
                want = cal_expected.pop_front();
                check_field("second_of_minute", int'(want.sec), int'(m_second_of_minute));
                check_field("minute_of_hour", int'(want.min), int'(m_minute_of_hour));
                check_field("hour_of_day", int'(want.hour), int'(m_hour_of_day));
                check_field("day_of_month", int'(want.dom), int'(m_day_of_month));
                check_field("month_of_year", int'(want.mon), int'(m_month_of_year));
                check_field("year_since_2000", int'(want.year), int'(m_year_since_2000));
                check_field("weekday", int'(want.wday), int'(m_weekday));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_hold <= 0;
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_ready <= 1'b0;
        end else if (sink_idle_en && $urandom_range(0, 99) < 25) begin
            sink_hold <= idle_len();
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic test_directed();
        logic [SECS_W-1:0] stamps[$];
        stamps = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399,
                   32'd86400, 32'd5097600, 32'd5184000, 32'd31622399, 32'd31622400,
                   32'd3160857599, 32'd3160857600, 32'h7FFFFFFF, 32'h80000000,
                   32'hAAAAAAAA, 32'h55555555, 32'hFFFFFFFE, 32'hFFFFFFFF};
        foreach (stamps[i]) begin
            send_stamp(stamps[i]);
        end
        // noon of Monday to Friday after the epoch; the list above gives Saturday and Sunday
        for (int i = 2; i < 7; i++) begin
            send_stamp(SECS_W'(i) * SECS_PER_DAY + 32'd43200);
        end
    endtask

    task automatic test_uniform(input int count);
        repeat (count) send_stamp($urandom);
    endtask

    // the seconds on either side of midnight of a random day
    task automatic test_day_edges(input int count);
        logic [SECS_W-1:0] day;
        repeat (count) begin
            day = $urandom_range(1, LAST_DAY);
            send_stamp(day * SECS_PER_DAY - 32'd1);
            send_stamp(day * SECS_PER_DAY);
        end
    endtask

    task automatic test_top_of_range(input int count);
        repeat (count) send_stamp(32'hFFFFFFFF - SECS_W'($urandom_range(0, 200000)));
    endtask

    task automatic test_back_to_back(input int count);
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        repeat (count) send_stamp($urandom);
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_uniform(200);
        test_day_edges(60);
        test_top_of_range(40);
        test_back_to_back(90);
        s_valid <= 1'b0;
        while (cal_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (cal_expected.size() != 0) begin
            $error("%0d results never arrived", cal_expected.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
